// ----- src/klt_pkg.sv -----
// klt_pkg: shared types and constants for the key lock tag extractor
// used by klt_front, klt_queue, klt_back and key_lock_tag_extractor
package klt_pkg;

  localparam int MAX_PREFIX_BYTES_DEF = 8;
  localparam int KEY_INDEX_BITS_DEF   = 16;

  localparam int DELIM_W      = 8;
  localparam int SKIP_W       = 8;
  localparam int PREFIX_W     = 64;
  localparam int PREFIX_LEN_W = 4;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int FIELD_W      = 16;
  localparam int CLOSE_CNT_W  = 9;

  localparam logic [DELIM_W-1:0] OPEN_DELIM_RST  = 8'd123;
  localparam logic [DELIM_W-1:0] CLOSE_DELIM_RST = 8'd125;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_OPEN_DELIM    = 3'd0,
    REG_CLOSE_DELIM   = 3'd1,
    REG_SKIP_COUNT    = 3'd2,
    REG_PREFIX_BYTES  = 3'd3,
    REG_PREFIX_LENGTH = 3'd4
  } klt_reg_t;

  // one classified key byte
  typedef struct packed {
    logic is_open;
    logic is_close;
    logic pfx_bad;
    logic last;
  } klt_item_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } klt_qstat_t;

endpackage

// ----- src/klt_front.sv -----
// klt_front: takes key bytes, compares them against delimiters and prefix
// depends on klt_pkg
module klt_front #(
  parameter int MAX_PREFIX_BYTES = klt_pkg::MAX_PREFIX_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [klt_pkg::DELIM_W-1:0]      key_byte,
  input  logic                             last_byte,
  input  logic                             accept,
  input  logic [klt_pkg::DELIM_W-1:0]      open_delim,
  input  logic [klt_pkg::DELIM_W-1:0]      close_delim,
  input  logic [klt_pkg::PREFIX_W-1:0]     prefix_bytes,
  input  logic [klt_pkg::PREFIX_LEN_W-1:0] prefix_length,
  output klt_pkg::klt_item_t               item
);
  import klt_pkg::*;

  localparam int CW = $clog2(MAX_PREFIX_BYTES + 1);

  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [PREFIX_LEN_W-1:0] plen;
  logic                    mismatch;
  logic [PREFIX_LEN_W:0]   cnt_inc;

  // prefix length above the limit counts as the limit
  assign plen = (prefix_length > PREFIX_LEN_W'(MAX_PREFIX_BYTES)) ?
                PREFIX_LEN_W'(MAX_PREFIX_BYTES) : prefix_length;

  always_comb begin
    mismatch = 1'b0;
    for (int i = 0; i < MAX_PREFIX_BYTES; i++) begin
      if ((int'(cnt_r) == i) && (i < int'(plen)) &&
          (key_byte != prefix_bytes[8*i +: 8])) begin
        mismatch = 1'b1;
      end
    end
  end

  assign cnt_inc = (PREFIX_LEN_W+1)'(cnt_r) + (PREFIX_LEN_W+1)'(1);

  always_comb begin
    item.is_open  = (key_byte == open_delim);
    item.is_close = (key_byte == close_delim);
    // key shorter than the prefix also fails the prefix
    item.pfx_bad  = mismatch || (last_byte && (cnt_inc < {1'b0, plen}));
    item.last     = last_byte;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (last_byte) begin
        cnt_nxt = '0;
      end else if (cnt_r != CW'(MAX_PREFIX_BYTES)) begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- src/klt_queue.sv -----
// klt_queue: short queue of classified bytes between front and back
// depends on klt_pkg
module klt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  klt_pkg::klt_item_t push_item,
  input  logic               pop,
  output klt_pkg::klt_item_t head_item,
  output klt_pkg::klt_qstat_t stat
);
  import klt_pkg::*;

  klt_item_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign head_item  = mem[rd_ptr_r];
  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign stat.count = cnt_r;

endmodule

// ----- src/klt_back.sv -----
// klt_back: per-key tag tracking and the result register
// depends on klt_pkg
module klt_back #(
  parameter int KEY_INDEX_BITS = klt_pkg::KEY_INDEX_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  klt_pkg::klt_item_t          head_item,
  input  logic                        head_valid,
  output logic                        pop,
  input  logic [klt_pkg::SKIP_W-1:0]  skip_count,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic                        res_found,
  output logic [klt_pkg::FIELD_W-1:0] res_offset,
  output logic [klt_pkg::FIELD_W-1:0] res_length,
  output logic                        res_too_long
);
  import klt_pkg::*;

  localparam int KW = KEY_INDEX_BITS;
  localparam logic [KW-1:0] KEY_MAX = '1;

  logic [KW-1:0]          pos_r, pos_nxt;
  logic                   pbad_r, pbad_nxt;
  logic                   open_r, open_nxt;
  logic [KW-1:0]          open_pos_r, open_pos_nxt;
  logic [KW-1:0]          last_pos_r, last_pos_nxt;
  logic [CLOSE_CNT_W-1:0] ccnt_r, ccnt_nxt;
  logic                   failed_r, failed_nxt;
  logic                   done_r, done_nxt;
  logic [KW-1:0]          end_r, end_nxt;
  logic                   ovf_r, ovf_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   found_r, found_nxt;
  logic [FIELD_W-1:0]     off_r, off_nxt;
  logic [FIELD_W-1:0]     len_r, len_nxt;
  logic                   tl_r, tl_nxt;

  logic                   found;
  logic [KW-1:0]          key_len;
  logic [KW-1:0]          tag_off;
  logic [KW-1:0]          tag_len;
  logic [KW+FIELD_W-1:0]  off_ext, len_ext, klen_ext;
  logic [CLOSE_CNT_W-1:0] ccnt_inc;

  // a result waits in the output register; bytes that give none never stall
  assign pop = head_valid && (!head_item.last || !out_valid_r || res_ready);

  assign ccnt_inc = ccnt_r + CLOSE_CNT_W'(1);

  always_comb begin
    pos_nxt      = pos_r;
    pbad_nxt     = pbad_r;
    open_nxt     = open_r;
    open_pos_nxt = open_pos_r;
    last_pos_nxt = last_pos_r;
    ccnt_nxt     = ccnt_r;
    failed_nxt   = failed_r;
    done_nxt     = done_r;
    end_nxt      = end_r;
    ovf_nxt      = ovf_r;
    if (pop) begin
      if (ovf_r || pos_r == KEY_MAX) begin
        ovf_nxt = 1'b1;
      end else begin
        pbad_nxt = pbad_r || head_item.pfx_bad;
        if (!open_r) begin
          if (head_item.is_open) begin
            open_nxt     = 1'b1;
            open_pos_nxt = pos_r;
            last_pos_nxt = pos_r;
          end
        end else if (!failed_r && !done_r && head_item.is_close) begin
          // close directly after the previous delimiter spoils the tag
          if ({1'b0, pos_r} == ({1'b0, last_pos_r} + (KW+1)'(1))) begin
            failed_nxt = 1'b1;
          end else begin
            ccnt_nxt     = ccnt_inc;
            last_pos_nxt = pos_r;
            if (ccnt_inc == ({1'b0, skip_count} + CLOSE_CNT_W'(1))) begin
              done_nxt = 1'b1;
              end_nxt  = pos_r;
            end
          end
        end
        pos_nxt = pos_r + KW'(1);
      end
    end
  end

  assign key_len = ovf_nxt ? KEY_MAX : pos_nxt;
  assign found   = !ovf_nxt && !pbad_nxt && open_nxt && done_nxt && !failed_nxt;
  assign tag_off = open_pos_nxt + KW'(1);
  assign tag_len = end_nxt - open_pos_nxt - KW'(1);

  // widen then keep the low field bits, whatever the index width
  assign off_ext  = {{FIELD_W{1'b0}}, tag_off};
  assign len_ext  = {{FIELD_W{1'b0}}, tag_len};
  assign klen_ext = {{FIELD_W{1'b0}}, key_len};

  always_comb begin
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    off_nxt       = off_r;
    len_nxt       = len_r;
    tl_nxt        = tl_r;
    if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop && head_item.last) begin
      out_valid_nxt = 1'b1;
      found_nxt     = found;
      off_nxt       = found ? off_ext[FIELD_W-1:0] : '0;
      len_nxt       = found ? len_ext[FIELD_W-1:0] : klen_ext[FIELD_W-1:0];
      tl_nxt        = ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (pop && head_item.last)) begin
      pos_r      <= '0;
      pbad_r     <= 1'b0;
      open_r     <= 1'b0;
      open_pos_r <= '0;
      last_pos_r <= '0;
      ccnt_r     <= '0;
      failed_r   <= 1'b0;
      done_r     <= 1'b0;
      end_r      <= '0;
      ovf_r      <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      pbad_r     <= pbad_nxt;
      open_r     <= open_nxt;
      open_pos_r <= open_pos_nxt;
      last_pos_r <= last_pos_nxt;
      ccnt_r     <= ccnt_nxt;
      failed_r   <= failed_nxt;
      done_r     <= done_nxt;
      end_r      <= end_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    off_r   <= off_nxt;
    len_r   <= len_nxt;
    tl_r    <= tl_nxt;
  end

  assign res_valid    = out_valid_r;
  assign res_found    = found_r;
  assign res_offset   = off_r;
  assign res_length   = len_r;
  assign res_too_long = tl_r;

endmodule

// ----- src/key_lock_tag_extractor.sv -----
// key_lock_tag_extractor: one key byte per cycle in unless stalled, one result per key out
// a last byte passes a queue entry, then the result register; it stalls while a result waits
// throughput: 1 byte per cycle unless the queue is full; the back stage updates per-key state
// once a cycle when it pops; the two-entry queue lets input keep moving while a result waits
// reset (rst_n low, synchronous): control registers return to defaults, key state clears
// depends on klt_pkg, klt_front, klt_queue, klt_back
module key_lock_tag_extractor #(
  parameter int MAX_PREFIX_BYTES = klt_pkg::MAX_PREFIX_BYTES_DEF,
  parameter int KEY_INDEX_BITS   = klt_pkg::KEY_INDEX_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // key_byte[7:0]
  input  logic                           in_tlast,   // last_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // tag_offset[15:0], tag_length[31:16]
  output logic [1:0]                     out_tuser,  // tag_found[0], too_long[1]
  input  logic                           cfg_we,
  input  logic [klt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [klt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import klt_pkg::*;

  logic [DELIM_W-1:0]      open_delim_r;
  logic [DELIM_W-1:0]      close_delim_r;
  logic [SKIP_W-1:0]       skip_count_r;
  logic [PREFIX_W-1:0]     prefix_bytes_r;
  logic [PREFIX_LEN_W-1:0] prefix_length_r;

  klt_item_t          front_item;
  klt_item_t          head_item;
  klt_qstat_t         qstat;
  logic               in_accept;
  logic               pop;
  logic               res_found;
  logic               res_too_long;
  logic [FIELD_W-1:0] res_offset;
  logic [FIELD_W-1:0] res_length;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_delim_r    <= OPEN_DELIM_RST;
      close_delim_r   <= CLOSE_DELIM_RST;
      skip_count_r    <= '0;
      prefix_bytes_r  <= '0;
      prefix_length_r <= '0;
    end else if (cfg_we) begin
      case (klt_reg_t'(cfg_addr))
        REG_OPEN_DELIM:    open_delim_r    <= cfg_wdata[DELIM_W-1:0];
        REG_CLOSE_DELIM:   close_delim_r   <= cfg_wdata[DELIM_W-1:0];
        REG_SKIP_COUNT:    skip_count_r    <= cfg_wdata[SKIP_W-1:0];
        REG_PREFIX_BYTES:  prefix_bytes_r  <= cfg_wdata[PREFIX_W-1:0];
        REG_PREFIX_LENGTH: prefix_length_r <= cfg_wdata[PREFIX_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !qstat.full;
  assign in_accept = in_tvalid && in_tready;

  klt_front #(
    .MAX_PREFIX_BYTES(MAX_PREFIX_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .key_byte     (in_tdata),
    .last_byte    (in_tlast),
    .accept       (in_accept),
    .open_delim   (open_delim_r),
    .close_delim  (close_delim_r),
    .prefix_bytes (prefix_bytes_r),
    .prefix_length(prefix_length_r),
    .item         (front_item)
  );

  klt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept),
    .push_item(front_item),
    .pop      (pop),
    .head_item(head_item),
    .stat     (qstat)
  );

  klt_back #(
    .KEY_INDEX_BITS(KEY_INDEX_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_item   (head_item),
    .head_valid  (!qstat.empty),
    .pop         (pop),
    .skip_count  (skip_count_r),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_found   (res_found),
    .res_offset  (res_offset),
    .res_length  (res_length),
    .res_too_long(res_too_long)
  );

  assign out_tdata = {res_length, res_offset};
  assign out_tuser = {res_too_long, res_found};

  // queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // back stage only consumes from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> qstat.count != '0)
    else $error("pop from empty queue");

  // an overlong key is always reported whole, at offset zero
  a_too_long_whole: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (!out_tuser[0] && out_tdata[15:0] == '0))
    else $error("overlong key reported with a tag");

  // a completed result on the last byte shows up on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_item.last) |=> out_tvalid)
    else $error("result lost after last byte");

endmodule

// ----- test/tb.sv -----
// tb: self-checking bench for key_lock_tag_extractor, with its own tag predictor
// streams keys with random gaps and back-pressure, checks every tag request in order
// depends on klt_pkg and the key_lock_tag_extractor rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import klt_pkg::*;

  localparam logic [15:0] POS_MAX = 16'hFFFF;
  localparam int SETTLE_CYCLES = 6;

  typedef struct packed {
    logic        found;
    logic [15:0] offset;
    logic [15:0] length;
    logic        too_long;
  } tag_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  key_lock_tag_extractor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // register copy held by the bench
  logic [7:0]  open_byte  = OPEN_DELIM_RST;
  logic [7:0]  close_byte = CLOSE_DELIM_RST;
  logic [7:0]  skip_closes = 8'd0;
  logic [63:0] prefix_val = 64'd0;
  logic [3:0]  prefix_len = 4'd0;

  // per-key tracking state
  logic [15:0] key_pos = '0;
  logic        pfx_match = 1'b1;
  logic        open_hit = 1'b0;
  logic [15:0] open_at = '0;
  logic [15:0] last_delim_at = '0;
  logic [8:0]  closes_seen = '0;
  logic        tag_broken = 1'b0;
  logic        tag_closed = 1'b0;
  logic [15:0] tag_end_at = '0;
  logic        key_overflow = 1'b0;

  tag_result_t expected_tags[$];
  logic [7:0]  key_bytes[$];
  int          error_count = 0;
  bit          calm = 1'b0;
  int          rx_hold_request = 0;

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    if (error_count < 40)
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  task automatic track_key_byte(input logic [7:0] b, input logic last);
    logic [3:0]  plen;
    logic [15:0] klen;
    tag_result_t r;
    plen = (prefix_len > 4'd8) ? 4'd8 : prefix_len;
    if (key_overflow || key_pos == POS_MAX) begin
      key_overflow = 1'b1;
    end else begin
      if (key_pos < {12'd0, plen} && b != prefix_val[{key_pos[2:0], 3'b000} +: 8])
        pfx_match = 1'b0;
      if (!open_hit) begin
        if (b == open_byte) begin
          open_hit = 1'b1;
          open_at = key_pos;
          last_delim_at = key_pos;
        end
      end else if (!tag_broken && !tag_closed && b == close_byte) begin
        // a close right after the previous delimiter spoils the tag
        if (key_pos == last_delim_at + 16'd1) begin
          tag_broken = 1'b1;
        end else begin
          closes_seen = closes_seen + 9'd1;
          last_delim_at = key_pos;
          if (closes_seen == {1'b0, skip_closes} + 9'd1) begin
            tag_closed = 1'b1;
            tag_end_at = key_pos;
          end
        end
      end
      key_pos = key_pos + 16'd1;
    end
    if (last) begin
      klen = key_overflow ? POS_MAX : key_pos;
      r.too_long = key_overflow;
      r.found = !key_overflow && pfx_match && klen >= {12'd0, plen} && open_hit &&
                tag_closed && !tag_broken;
      if (r.found) begin
        r.offset = open_at + 16'd1;
        r.length = tag_end_at - open_at - 16'd1;
      end else begin
        r.offset = '0;
        r.length = klen;
      end
      expected_tags.push_back(r);
      key_pos = '0;
      pfx_match = 1'b1;
      open_hit = 1'b0;
      open_at = '0;
      last_delim_at = '0;
      closes_seen = '0;
      tag_broken = 1'b0;
      tag_closed = 1'b0;
      tag_end_at = '0;
      key_overflow = 1'b0;
    end
  endtask

  function automatic int gap_len();
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 70)
      return 0;
    if (r < 95)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == open_byte || b == close_byte)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, input int gap);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    track_key_byte(b, last);
  endtask

  task automatic send_key();
    for (int i = 0; i < key_bytes.size(); i++)
      send_byte(key_bytes[i], i == key_bytes.size() - 1, gap_len());
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      key_bytes.push_back(s[i]);
  endtask

  // stop offering bytes and let every outstanding request come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_tags.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input klt_reg_t idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // unused upper bits of the write data carry random junk
  task automatic apply_config(input logic [7:0] open_v, input logic [7:0] close_v,
                              input logic [7:0] skip_v, input logic [63:0] pfx_v,
                              input logic [3:0] plen_v);
    logic [63:0] junk;
    drain();
    junk = {$urandom, $urandom};
    write_reg(REG_OPEN_DELIM, {junk[63:8], open_v});
    write_reg(REG_CLOSE_DELIM, {junk[55:0], close_v});
    write_reg(REG_SKIP_COUNT, {junk[63:8] ^ junk[55:0], skip_v});
    write_reg(REG_PREFIX_BYTES, pfx_v);
    write_reg(REG_PREFIX_LENGTH, {junk[59:0], plen_v});
    cfg_we <= 1'b0;
    open_byte = open_v;
    close_byte = close_v;
    skip_closes = skip_v;
    prefix_val = pfx_v;
    prefix_len = plen_v;
  endtask

  task automatic make_random_key();
    int         plen;
    int         need;
    int         idx;
    logic [7:0] flip;
    key_bytes.delete();
    plen = (prefix_len > 4'd8) ? 8 : int'(prefix_len);
    if ($urandom_range(0, 9) < 8) begin
      // well-formed shape with random content
      if (plen > 0 && $urandom_range(0, 3) != 0) begin
        for (int i = 0; i < plen; i++)
          key_bytes.push_back(prefix_val[8*i +: 8]);
        if ($urandom_range(0, 7) == 0) begin
          idx = $urandom_range(0, key_bytes.size() - 1);
          flip = 8'($urandom_range(1, 255));
          key_bytes[idx] = key_bytes[idx] ^ flip;
        end
      end
      repeat ($urandom_range(0, 3)) key_bytes.push_back(plain_byte());
      if ($urandom_range(0, 9) != 0)
        key_bytes.push_back(open_byte);
      need = int'(skip_closes) + 1;
      if ($urandom_range(0, 5) == 0)
        need = $urandom_range(0, int'(skip_closes));
      for (int c = 0; c < need; c++) begin
        if ($urandom_range(0, 9) != 0)
          repeat ($urandom_range(1, (int'(skip_closes) > 8) ? 2 : 3))
            key_bytes.push_back(plain_byte());
        key_bytes.push_back(close_byte);
      end
      repeat ($urandom_range(0, 3)) key_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      // noise leaning on the delimiter values
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 2) == 0)
          key_bytes.push_back($urandom_range(0, 1) ? open_byte : close_byte);
        else
          key_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    if (key_bytes.size() == 0)
      key_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // result side: checks each accepted request, then picks the next ready level
  initial begin
    tag_result_t want;
    int          hold_off;
    hold_off = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1) begin
        if (expected_tags.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[15:0], 16'd0);
        end else begin
          want = expected_tags.pop_front();
          if (out_tuser[0] !== want.found)
            report_mismatch("tag_found", 16'(out_tuser[0]), 16'(want.found));
          if (out_tdata[15:0] !== want.offset)
            report_mismatch("tag_offset", out_tdata[15:0], want.offset);
          if (out_tdata[31:16] !== want.length)
            report_mismatch("tag_length", out_tdata[31:16], want.length);
          if (out_tuser[1] !== want.too_long)
            report_mismatch("too_long", 16'(out_tuser[1]), 16'(want.too_long));
        end
      end
      if (rx_hold_request > 0) begin
        hold_off = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_tready <= 1'b0;
      end else if (calm || $urandom_range(0, 9) != 0) begin
        out_tready <= 1'b1;
      end else begin
        hold_off = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        out_tready <= 1'b0;
      end
    end
  end

  // reset values, prefix handling, equal delimiters, empty tag, byte extremes
  task automatic test_directed();
    key_bytes.delete();
    push_text("a{bc}");
    send_key();
    key_bytes.delete();
    push_text("{}");
    send_key();
    key_bytes.delete();
    key_bytes.push_back(8'hFF);
    send_key();

    apply_config(8'h7C, 8'h7C, 8'd1, 64'h3A6B, 4'd2);
    key_bytes.delete();
    push_text("k:|a|b|");
    send_key();
    key_bytes.delete();
    push_text("k");
    send_key();

    // prefix length above eight, key shorter than the prefix
    apply_config(8'h00, 8'hFF, 8'd0, 64'd0, 4'd15);
    key_bytes.delete();
    key_bytes.push_back(8'h00);
    key_bytes.push_back(8'h41);
    key_bytes.push_back(8'hFF);
    send_key();

    apply_config(8'h00, 8'hFF, 8'd0, 64'd0, 4'd0);
    send_key();
  endtask

  task automatic test_random_keys();
    int sent;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: apply_config(8'h7B, 8'h7D, 8'd0, {$urandom, $urandom}, 4'd0);
        1: apply_config(8'h00, 8'h00, 8'd0, {$urandom, $urandom}, 4'd0);
        2: apply_config(8'hFF, 8'h00, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        3: apply_config(8'($urandom), 8'($urandom), 8'($urandom_range(1, 3)),
                        {$urandom, $urandom}, 4'($urandom_range(1, 7)));
        4: apply_config(8'($urandom), 8'($urandom), 8'd0, {$urandom, $urandom}, 4'd15);
        5: apply_config(8'($urandom), 8'($urandom), 8'($urandom_range(0, 2)),
                        {$urandom, $urandom}, 4'($urandom_range(9, 14)));
        6: apply_config(8'h5B, 8'h5D, 8'd2, {$urandom, $urandom}, 4'd4);
        default: apply_config(8'($urandom), 8'($urandom), 8'($urandom_range(0, 4)),
                              {$urandom, $urandom}, 4'($urandom_range(0, 15)));
      endcase
      calm = (phase == 3);
      sent = 0;
      while (sent < 130) begin
        make_random_key();
        send_key();
        sent += key_bytes.size();
      end
    end
    calm = 1'b0;
  endtask

  // results held back long enough for the input side to stall
  task automatic test_result_stall();
    drain();
    calm = 1'b1;
    rx_hold_request = 300;
    repeat (80) begin
      key_bytes.delete();
      if ($urandom_range(0, 1))
        push_text("{x}");
      else
        repeat ($urandom_range(1, 3)) key_bytes.push_back(8'($urandom_range(0, 255)));
      send_key();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_keys();
    test_result_stall();
    drain();
    if (error_count == 0)
      $display("[key_lock_tag_extractor] OK");
    else
      $display("[key_lock_tag_extractor] ERROR");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[key_lock_tag_extractor] ERROR");
    $finish;
  end

endmodule
